// ----- hw/rtl/lfca_pkg.sv -----
`timescale 1ns / 1ps

package lfca_pkg;

	localparam int unsigned TIME_W       = 64;
	localparam int unsigned MS_W         = 32;
	localparam int unsigned PERF_W       = 16;
	localparam int unsigned COUNT_W      = 16;
	localparam int unsigned FAULT_W      = 3;
	localparam int unsigned FUNC_W       = 2;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 32;
	localparam int unsigned TICKS_PER_MS = 1000;
	localparam int unsigned EDGES_PER_PERF = 2;

	// Millisecond limits scaled to ticks: 32 bits times 1000 fits in 42 bits.
	localparam int unsigned TICK_LIM_W = MS_W + 10;
	// Transition limit (max_perforations + 1) * 2 fits in 18 bits.
	localparam int unsigned EDGE_LIM_W = PERF_W + 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RECORD = 2'd0,
		FUNC_AUDIT  = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE      = 3'd0,
		FAULT_NO_NOSE   = 3'd1,
		FAULT_NO_TAIL   = 3'd2,
		FAULT_TOO_LONG  = 3'd3,
		FAULT_TOO_SHORT = 3'd4,
		FAULT_TOO_MANY  = 3'd5
	} fault_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_CAR_MS       = 2'd0,
		CFG_MIN_CAR_MS       = 2'd1,
		CFG_MAX_PERFORATIONS = 2'd2
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic rec_en;
		logic clr_en;
		logic span_en;
		logic judge_en;
	} lfca_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} lfca_sts_t;

endpackage

// ----- hw/rtl/lfca_req_if.sv -----
`timescale 1ns / 1ps

interface lfca_req_if import lfca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [TIME_W-1:0] capture_time;

	modport source (output valid, output func, output capture_time, input ready);
	modport sink   (input valid, input func, input capture_time, output ready);
endinterface

// ----- hw/rtl/lfca_rsp_if.sv -----
`timescale 1ns / 1ps

interface lfca_rsp_if import lfca_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FAULT_W-1:0] fault;
	logic [TIME_W-1:0]  car_span_ticks;
	logic [COUNT_W-1:0] edge_count;

	modport source (output valid, output fault, output car_span_ticks, output edge_count,
		input ready);
	modport sink   (input valid, input fault, input car_span_ticks, input edge_count,
		output ready);
endinterface

// ----- hw/rtl/lfca_cfg_if.sv -----
`timescale 1ns / 1ps

interface lfca_cfg_if import lfca_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lfca_ctrl.sv -----
`timescale 1ns / 1ps

module lfca_ctrl import lfca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [FUNC_W-1:0] req_func,
	output logic              req_ready,
	input  lfca_sts_t         sts,
	output lfca_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPAN,
		ST_JUDGE
	} state_t;

	state_t state_q;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd          = '0;
		cmd.rec_en   = accept && (req_func == FUNC_RECORD);
		cmd.clr_en   = accept && (req_func == FUNC_CLEAR);
		cmd.span_en  = (state_q == ST_SPAN);
		cmd.judge_en = (state_q == ST_JUDGE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_func == FUNC_AUDIT)) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					state_q <= ST_JUDGE;
				end
				ST_JUDGE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/lfca_dp.sv -----
`timescale 1ns / 1ps

module lfca_dp import lfca_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfca_cmd_t             cmd,
	output lfca_sts_t             sts,
	input  logic [TIME_W-1:0]     capture_time,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [FAULT_W-1:0]    rsp_fault,
	output logic [TIME_W-1:0]     rsp_span,
	output logic [COUNT_W-1:0]    rsp_count
);

	logic [TICK_LIM_W-1:0] hi_ticks_q;
	logic [TICK_LIM_W-1:0] lo_ticks_q;
	logic [EDGE_LIM_W-1:0] edge_lim_q;

	logic [TIME_W-1:0]  earliest_q;
	logic [TIME_W-1:0]  latest_q;
	logic               have_nose_q;
	logic               have_tail_q;
	logic [COUNT_W-1:0] count_q;

	logic [TIME_W-1:0]  span_s1;

	logic               out_valid_q;
	fault_t             fault_q;
	logic [TIME_W-1:0]  span_q;
	logic [COUNT_W-1:0] out_count_q;

	fault_t             fault_d;

	assign sts.out_free = !out_valid_q || rsp_ready;

	// Limits are scaled once, when the register is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_ticks_q <= '0;
			lo_ticks_q <= '0;
			edge_lim_q <= EDGE_LIM_W'(EDGES_PER_PERF);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_CAR_MS: begin
					hi_ticks_q <= TICK_LIM_W'(cfg_data) * TICK_LIM_W'(TICKS_PER_MS);
				end
				CFG_MIN_CAR_MS: begin
					lo_ticks_q <= TICK_LIM_W'(cfg_data) * TICK_LIM_W'(TICKS_PER_MS);
				end
				CFG_MAX_PERFORATIONS: begin
					edge_lim_q <= (EDGE_LIM_W'(cfg_data[PERF_W-1:0]) + EDGE_LIM_W'(1))
						* EDGE_LIM_W'(EDGES_PER_PERF);
				end
				default: begin
				end
			endcase
		end
	end

	// Per-car state: ties never replace the stored nose or tail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_q  <= '0;
			latest_q    <= '0;
			have_nose_q <= 1'b0;
			have_tail_q <= 1'b0;
			count_q     <= '0;
		end else if (cmd.clr_en) begin
			earliest_q  <= '0;
			latest_q    <= '0;
			have_nose_q <= 1'b0;
			have_tail_q <= 1'b0;
			count_q     <= '0;
		end else if (cmd.rec_en) begin
			if (!have_nose_q || (capture_time < earliest_q)) begin
				earliest_q  <= capture_time;
				have_nose_q <= 1'b1;
			end
			if (!have_tail_q || (capture_time > latest_q)) begin
				latest_q    <= capture_time;
				have_tail_q <= 1'b1;
			end
			if (count_q != {COUNT_W{1'b1}}) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.span_en) begin
			span_s1 <= (have_nose_q && have_tail_q) ? (latest_q - earliest_q) : '0;
		end
	end

	always_comb begin
		if (!have_nose_q) begin
			fault_d = FAULT_NO_NOSE;
		end else if (!have_tail_q) begin
			fault_d = FAULT_NO_TAIL;
		end else if (span_s1 > TIME_W'(hi_ticks_q)) begin
			fault_d = FAULT_TOO_LONG;
		end else if (span_s1 < TIME_W'(lo_ticks_q)) begin
			fault_d = FAULT_TOO_SHORT;
		end else if (EDGE_LIM_W'(count_q) > edge_lim_q) begin
			fault_d = FAULT_TOO_MANY;
		end else begin
			fault_d = FAULT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.judge_en) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.judge_en) begin
			fault_q     <= fault_d;
			span_q      <= have_nose_q ? span_s1 : '0;
			out_count_q <= count_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_fault = fault_q;
	assign rsp_span  = span_q;
	assign rsp_count = out_count_q;

endmodule

// ----- hw/rtl/lane_finish_capture_audit_core.sv -----
`timescale 1ns / 1ps

// Lane finish capture audit.
// The req channel carries one command per transfer: record a capture time,
// audit the current car, or clear for the next car. Record and clear take
// effect in the cycle of their transfer and produce nothing on rsp. An audit
// produces exactly one rsp transfer holding a fault code, the nose to tail
// span in ticks and the saturating transition count.
// Record and clear leave req ready, so they can arrive back to back.
// An audit forms the span with the 64-bit subtractor in its span state, then
// does the limit compares in its judge state; the result then sits in the
// output register. A new request is taken once the result is loaded, even
// while the receiver has not yet taken it.
// If rsp stalls, the controller waits in its judge state until the output
// register is free, and req stays not ready during that time.
// The cfg channel is always ready; millisecond limits are scaled to ticks as
// they are written. Write cfg only while no audit is in flight.
// Reset clears the car state, the time limits and the output valid at once.

module lane_finish_capture_audit_core import lfca_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lfca_req_if.sink   req,
	lfca_rsp_if.source rsp,
	lfca_cfg_if.sink   cfg
);

	lfca_cmd_t cmd;
	lfca_sts_t sts;

	assign cfg.ready = 1'b1;

	lfca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfca_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.capture_time (req.capture_time),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_fault    (rsp.fault),
		.rsp_span     (rsp.car_span_ticks),
		.rsp_count    (rsp.edge_count)
	);

	// An accepted audit makes the block busy in the following cycle.
	a_audit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.func == FUNC_AUDIT)) |=> !req.ready)
		else $error("request accepted while an audit is in flight");

	// Nose and tail are always captured together.
	a_no_lone_nose: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.fault != FAULT_NO_TAIL))
		else $error("nose reported without a tail");

	// Without a nose nothing was recorded, so span and count are zero.
	a_empty_car: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.fault == FAULT_NO_NOSE)) |->
		((rsp.car_span_ticks == '0) && (rsp.edge_count == '0)))
		else $error("empty car reports span or count");

	// A clean audit implies at least one recorded transition.
	a_clean_has_edges: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.fault == FAULT_NONE)) |-> (rsp.edge_count != '0))
		else $error("clean audit with no transitions");

endmodule
